@@ hdl/tfvs_pkg.sv @@
// shared types, constants and decode tables of the tank fill and vent sequencer
package tfvs_pkg;

    localparam int TIME_W     = 32;
    localparam int PRESSURE_W = 24;
    localparam int LEVEL_W    = 23;
    localparam int BAND_W     = 20;
    localparam int STATE_W    = 5;
    localparam int MODE_W     = 5;
    localparam int ACTION_W   = 2;
    localparam int RELAY_IN_W = 8;
    localparam int CUSTOM_W   = 6;
    localparam int RELAY_W    = 7;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEVEL_W;
    localparam int CMP_W      = ((PRESSURE_W > LEVEL_W + 2) ? PRESSURE_W : LEVEL_W + 2) + 1;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MODE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CUSTOM = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 2'd3;

    // detailed states
    localparam logic [STATE_W-1:0] ST_STANDBY    = 5'd0;
    localparam logic [STATE_W-1:0] ST_KEEP_IN    = 5'd1;
    localparam logic [STATE_W-1:0] ST_KEEP_HIGH  = 5'd2;
    localparam logic [STATE_W-1:0] ST_KEEP_LOW   = 5'd3;
    localparam logic [STATE_W-1:0] ST_FILL_HI    = 5'd4;
    localparam logic [STATE_W-1:0] ST_FILL_LO    = 5'd5;
    localparam logic [STATE_W-1:0] ST_PURGE_HI   = 5'd6;
    localparam logic [STATE_W-1:0] ST_PURGE_LO   = 5'd7;
    localparam logic [STATE_W-1:0] ST_PFA_HI     = 5'd8;
    localparam logic [STATE_W-1:0] ST_PFA_LO     = 5'd9;
    localparam logic [STATE_W-1:0] ST_PFB_HI     = 5'd10;
    localparam logic [STATE_W-1:0] ST_PFB_LO     = 5'd11;
    localparam logic [STATE_W-1:0] ST_PFC_HI     = 5'd12;
    localparam logic [STATE_W-1:0] ST_PFC_LO     = 5'd13;
    localparam logic [STATE_W-1:0] ST_PVA        = 5'd14;
    localparam logic [STATE_W-1:0] ST_PVB        = 5'd15;
    localparam logic [STATE_W-1:0] ST_PVC        = 5'd16;
    localparam logic [STATE_W-1:0] ST_PPA_HI     = 5'd17;
    localparam logic [STATE_W-1:0] ST_PPA_LO     = 5'd18;
    localparam logic [STATE_W-1:0] ST_PPB_HI     = 5'd19;
    localparam logic [STATE_W-1:0] ST_PPB_LO     = 5'd20;
    localparam logic [STATE_W-1:0] ST_PPC_HI     = 5'd21;
    localparam logic [STATE_W-1:0] ST_PPC_LO     = 5'd22;
    localparam logic [STATE_W-1:0] ST_FIRE_IGN   = 5'd23;
    localparam logic [STATE_W-1:0] ST_FIRE_BUF   = 5'd24;
    localparam logic [STATE_W-1:0] ST_FIRE_VALVE = 5'd25;
    localparam logic [STATE_W-1:0] ST_MAN_IGN    = 5'd26;
    localparam logic [STATE_W-1:0] ST_MAN_VALVE  = 5'd27;
    localparam logic [STATE_W-1:0] ST_ABORT      = 5'd28;
    localparam logic [STATE_W-1:0] ST_CUSTOM     = 5'd29;

    // reported modes
    localparam logic [MODE_W-1:0] MODE_STANDBY   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_KEEP      = 5'd1;
    localparam logic [MODE_W-1:0] MODE_FILL      = 5'd2;
    localparam logic [MODE_W-1:0] MODE_PURGE     = 5'd3;
    localparam logic [MODE_W-1:0] MODE_PFA       = 5'd4;
    localparam logic [MODE_W-1:0] MODE_PFB       = 5'd5;
    localparam logic [MODE_W-1:0] MODE_PFC       = 5'd6;
    localparam logic [MODE_W-1:0] MODE_PVA       = 5'd7;
    localparam logic [MODE_W-1:0] MODE_PVB       = 5'd8;
    localparam logic [MODE_W-1:0] MODE_PVC       = 5'd9;
    localparam logic [MODE_W-1:0] MODE_PPA       = 5'd10;
    localparam logic [MODE_W-1:0] MODE_PPB       = 5'd11;
    localparam logic [MODE_W-1:0] MODE_PPC       = 5'd12;
    localparam logic [MODE_W-1:0] MODE_FIRE      = 5'd13;
    localparam logic [MODE_W-1:0] MODE_MAN_IGN   = 5'd14;
    localparam logic [MODE_W-1:0] MODE_MAN_VALVE = 5'd15;
    localparam logic [MODE_W-1:0] MODE_ABORT     = 5'd16;
    localparam logic [MODE_W-1:0] MODE_CUSTOM    = 5'd17;

    // relay bits: fill, vent, abort, cutter, igniter, valve, valve attach
    localparam logic [RELAY_W-1:0] R_NONE = 7'b0000000;
    localparam logic [RELAY_W-1:0] R_F    = 7'b0000001;
    localparam logic [RELAY_W-1:0] R_V    = 7'b0000010;
    localparam logic [RELAY_W-1:0] R_A    = 7'b0000100;
    localparam logic [RELAY_W-1:0] R_I    = 7'b0010000;
    localparam logic [RELAY_W-1:0] R_S    = 7'b0100000;
    localparam logic [RELAY_W-1:0] R_T    = 7'b1000000;
    localparam int VALVE_BIT = 5;

    // timer limits in ms
    localparam logic [LIMIT_W-1:0] LIM_NONE  = 15'd0;
    localparam logic [LIMIT_W-1:0] LIM_500   = 15'd500;
    localparam logic [LIMIT_W-1:0] LIM_1000  = 15'd1000;
    localparam logic [LIMIT_W-1:0] LIM_2000  = 15'd2000;
    localparam logic [LIMIT_W-1:0] LIM_5000  = 15'd5000;
    localparam logic [LIMIT_W-1:0] LIM_10000 = 15'd10000;
    localparam logic [LIMIT_W-1:0] LIM_30000 = 15'd30000;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [TIME_W-1:0]     now_ms;
        logic [PRESSURE_W-1:0] pressure;
        logic [MODE_W-1:0]     mode_request;
        logic [RELAY_IN_W-1:0] relay_bits;
    } t_req;

    typedef struct packed {
        logic              fill_on;
        logic              vent_on;
        logic              abort_on;
        logic              cutter_on;
        logic              igniter_on;
        logic              valve_open;
        logic              valve_attached;
        logic [MODE_W-1:0] op_mode;
    } t_result;

    typedef struct packed {
        logic [STATE_W-1:0]  detail;
        logic [TIME_W-1:0]   entered;
        logic [CUSTOM_W-1:0] custom;
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] abort_level;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] min_level;
        logic [BAND_W-1:0]  band;
    } t_cfg;

    function automatic logic [MODE_W-1:0] mode_of(input logic [STATE_W-1:0] s);
        case (s) inside
            ST_STANDBY:                                 mode_of = MODE_STANDBY;
            [ST_KEEP_IN:ST_KEEP_LOW]:                   mode_of = MODE_KEEP;
            ST_FILL_HI, ST_FILL_LO:                     mode_of = MODE_FILL;
            ST_PURGE_HI, ST_PURGE_LO:                   mode_of = MODE_PURGE;
            ST_PFA_HI, ST_PFA_LO:                       mode_of = MODE_PFA;
            ST_PFB_HI, ST_PFB_LO:                       mode_of = MODE_PFB;
            ST_PFC_HI, ST_PFC_LO:                       mode_of = MODE_PFC;
            ST_PVA:                                     mode_of = MODE_PVA;
            ST_PVB:                                     mode_of = MODE_PVB;
            ST_PVC:                                     mode_of = MODE_PVC;
            ST_PPA_HI, ST_PPA_LO:                       mode_of = MODE_PPA;
            ST_PPB_HI, ST_PPB_LO:                       mode_of = MODE_PPB;
            ST_PPC_HI, ST_PPC_LO:                       mode_of = MODE_PPC;
            [ST_FIRE_IGN:ST_FIRE_VALVE]:                mode_of = MODE_FIRE;
            ST_MAN_IGN:                                 mode_of = MODE_MAN_IGN;
            ST_MAN_VALVE:                               mode_of = MODE_MAN_VALVE;
            ST_ABORT:                                   mode_of = MODE_ABORT;
            ST_CUSTOM:                                  mode_of = MODE_CUSTOM;
            default:                                    mode_of = MODE_STANDBY;
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] entry_of(input logic [MODE_W-1:0] m);
        case (m) inside
            MODE_STANDBY:   entry_of = ST_STANDBY;
            MODE_KEEP:      entry_of = ST_KEEP_IN;
            MODE_FILL:      entry_of = ST_FILL_LO;
            MODE_PURGE:     entry_of = ST_PURGE_LO;
            MODE_PFA:       entry_of = ST_PFA_LO;
            MODE_PFB:       entry_of = ST_PFB_LO;
            MODE_PFC:       entry_of = ST_PFC_LO;
            MODE_PVA:       entry_of = ST_PVA;
            MODE_PVB:       entry_of = ST_PVB;
            MODE_PVC:       entry_of = ST_PVC;
            MODE_PPA:       entry_of = ST_PPA_LO;
            MODE_PPB:       entry_of = ST_PPB_LO;
            MODE_PPC:       entry_of = ST_PPC_LO;
            MODE_FIRE:      entry_of = ST_FIRE_IGN;
            MODE_MAN_IGN:   entry_of = ST_MAN_IGN;
            MODE_MAN_VALVE: entry_of = ST_MAN_VALVE;
            MODE_ABORT:     entry_of = ST_ABORT;
            default:        entry_of = ST_STANDBY;
        endcase
    endfunction

    function automatic logic [RELAY_W-1:0] relays_of(input logic [STATE_W-1:0] s);
        case (s) inside
            ST_FILL_LO, ST_PFA_LO, ST_PFB_LO, ST_PFC_LO, ST_KEEP_LOW:
                relays_of = R_F;
            ST_KEEP_HIGH, ST_FILL_HI, ST_PURGE_HI, ST_PFA_HI, ST_PFB_HI, ST_PFC_HI,
            [ST_PVA:ST_PPA_HI], ST_PPB_HI, ST_PPC_HI:
                relays_of = R_V;
            ST_PURGE_LO, ST_PPA_LO, ST_PPB_LO, ST_PPC_LO:
                relays_of = R_F | R_V;
            ST_FIRE_IGN, ST_MAN_IGN:
                relays_of = R_I | R_T;
            ST_FIRE_BUF:
                relays_of = R_T;
            ST_FIRE_VALVE, ST_MAN_VALVE:
                relays_of = R_S | R_T;
            ST_ABORT:
                relays_of = R_A;
            default:
                relays_of = R_NONE;
        endcase
    endfunction

    // state watches for pressure dropping below the abort band, partner is next code
    function automatic logic is_abort_hi(input logic [STATE_W-1:0] s);
        case (s) inside
            ST_FILL_HI, ST_PURGE_HI, ST_PFA_HI, ST_PFB_HI, ST_PFC_HI,
            ST_PPA_HI, ST_PPB_HI, ST_PPC_HI: is_abort_hi = 1'b1;
            default:                         is_abort_hi = 1'b0;
        endcase
    endfunction

    // state watches for pressure rising above the abort band, partner is previous code
    function automatic logic is_abort_lo(input logic [STATE_W-1:0] s);
        case (s) inside
            ST_FILL_LO, ST_PURGE_LO, ST_PFA_LO, ST_PFB_LO, ST_PFC_LO,
            ST_PPA_LO, ST_PPB_LO, ST_PPC_LO: is_abort_lo = 1'b1;
            default:                         is_abort_lo = 1'b0;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] limit_of(input logic [STATE_W-1:0] s);
        case (s) inside
            ST_PFA_LO, ST_PVA, ST_PPA_LO: limit_of = LIM_1000;
            ST_PVB, ST_PPB_LO:            limit_of = LIM_2000;
            ST_PFB_LO, ST_PVC, ST_PPC_LO: limit_of = LIM_5000;
            ST_PFC_LO, ST_FIRE_IGN:       limit_of = LIM_10000;
            ST_FIRE_BUF:                  limit_of = LIM_500;
            ST_FIRE_VALVE:                limit_of = LIM_30000;
            default:                      limit_of = LIM_NONE;
        endcase
    endfunction

endpackage

@@ hdl/tfvs_req_if.sv @@
// request channel: one tick, mode command or custom relay load
interface tfvs_req_if;
    import tfvs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [TIME_W-1:0]     now_ms;
    logic [PRESSURE_W-1:0] pressure;
    logic [MODE_W-1:0]     mode_request;
    logic [RELAY_IN_W-1:0] relay_bits;

    modport source (output valid, action, now_ms, pressure, mode_request, relay_bits,
                    input ready);
    modport sink (input valid, action, now_ms, pressure, mode_request, relay_bits,
                  output ready);
endinterface

@@ hdl/tfvs_rsp_if.sv @@
// result channel: relay drives and reported mode
interface tfvs_rsp_if;
    import tfvs_pkg::*;

    logic              valid;
    logic              ready;
    logic              fill_on;
    logic              vent_on;
    logic              abort_on;
    logic              cutter_on;
    logic              igniter_on;
    logic              valve_open;
    logic              valve_attached;
    logic [MODE_W-1:0] op_mode;

    modport source (output valid, fill_on, vent_on, abort_on, cutter_on, igniter_on,
                    valve_open, valve_attached, op_mode, input ready);
    modport sink (input valid, fill_on, vent_on, abort_on, cutter_on, igniter_on,
                  valve_open, valve_attached, op_mode, output ready);
endinterface

@@ hdl/tfvs_step.sv @@
// next-state and relay decode for one request
module tfvs_step (
    input  tfvs_pkg::t_state  i_cur,
    input  tfvs_pkg::t_req    i_req,
    input  tfvs_pkg::t_cfg    i_cfg,
    output tfvs_pkg::t_state  o_nxt,
    output tfvs_pkg::t_result o_res
);
    import tfvs_pkg::*;

    logic signed [CMP_W-1:0] p_ext;
    logic signed [CMP_W-1:0] band_ext;
    logic                    ab_hi, ab_lo, mx_hi, mx_lo, mn_hi, mn_lo;
    logic [TIME_W-1:0]       elapsed;
    logic [LIMIT_W-1:0]      lim;
    logic                    timed_out;
    logic                    go;
    logic [STATE_W-1:0]      tgt;
    logic [RELAY_W-1:0]      rel;
    logic [CUSTOM_W-1:0]     cr;

    function automatic logic above(input logic signed [CMP_W-1:0] p,
                                   input logic [LEVEL_W-1:0] lvl,
                                   input logic signed [CMP_W-1:0] b);
        logic signed [CMP_W-1:0] l;
        l = $signed({{(CMP_W-LEVEL_W){1'b0}}, lvl});
        above = p > (l + b);
    endfunction

    function automatic logic below(input logic signed [CMP_W-1:0] p,
                                   input logic [LEVEL_W-1:0] lvl,
                                   input logic signed [CMP_W-1:0] b);
        logic signed [CMP_W-1:0] l;
        l = $signed({{(CMP_W-LEVEL_W){1'b0}}, lvl});
        below = p < (l - b);
    endfunction

    assign p_ext    = $signed({{(CMP_W-PRESSURE_W){i_req.pressure[PRESSURE_W-1]}},
                               i_req.pressure});
    assign band_ext = $signed({{(CMP_W-BAND_W){1'b0}}, i_cfg.band});

    assign ab_hi = above(p_ext, i_cfg.abort_level, band_ext);
    assign ab_lo = below(p_ext, i_cfg.abort_level, band_ext);
    assign mx_hi = above(p_ext, i_cfg.max_level, band_ext);
    assign mx_lo = below(p_ext, i_cfg.max_level, band_ext);
    assign mn_hi = above(p_ext, i_cfg.min_level, band_ext);
    assign mn_lo = below(p_ext, i_cfg.min_level, band_ext);

    assign elapsed   = i_req.now_ms - i_cur.entered;
    assign lim       = limit_of(i_cur.detail);
    assign timed_out = (lim != LIM_NONE) && (elapsed > TIME_W'(lim));

    always_comb begin
        go    = 1'b0;
        tgt   = i_cur.detail;
        o_nxt = i_cur;
        unique case (i_req.action)
            ACT_TICK: begin
                if (i_cur.detail == ST_KEEP_IN) begin
                    if (mx_hi) begin
                        go  = 1'b1;
                        tgt = ST_KEEP_HIGH;
                    end else if (mn_lo) begin
                        go  = 1'b1;
                        tgt = ST_KEEP_LOW;
                    end
                end else if (i_cur.detail == ST_KEEP_HIGH) begin
                    go  = mx_lo;
                    tgt = ST_KEEP_IN;
                end else if (i_cur.detail == ST_KEEP_LOW) begin
                    go  = mn_hi;
                    tgt = ST_KEEP_IN;
                end else if (is_abort_hi(i_cur.detail)) begin
                    go  = ab_lo;
                    tgt = i_cur.detail + 5'd1;
                end else if (is_abort_lo(i_cur.detail)) begin
                    if (ab_hi) begin
                        go  = 1'b1;
                        tgt = i_cur.detail - 5'd1;
                    end else if (timed_out) begin
                        go  = 1'b1;
                        tgt = ST_STANDBY;
                    end
                end else if (i_cur.detail == ST_FIRE_IGN) begin
                    go  = timed_out;
                    tgt = ST_FIRE_BUF;
                end else if (i_cur.detail == ST_FIRE_BUF) begin
                    go  = timed_out;
                    tgt = ST_FIRE_VALVE;
                end else begin
                    go  = timed_out;
                    tgt = ST_STANDBY;
                end
            end
            ACT_MODE: begin
                go  = i_req.mode_request < MODE_CUSTOM;
                tgt = entry_of(i_req.mode_request);
            end
            ACT_CUSTOM: begin
                go           = 1'b1;
                tgt          = ST_CUSTOM;
                o_nxt.custom = i_req.relay_bits[CUSTOM_W-1:0];
            end
            default: begin
            end
        endcase
        if (go) begin
            o_nxt.detail  = tgt;
            o_nxt.entered = i_req.now_ms;
        end
    end

    always_comb begin
        cr = o_nxt.custom;
        if (o_nxt.detail == ST_CUSTOM) begin
            rel = {cr[VALVE_BIT], cr};
        end else begin
            rel = relays_of(o_nxt.detail);
        end
        o_res.fill_on        = rel[0];
        o_res.vent_on        = rel[1];
        o_res.abort_on       = rel[2];
        o_res.cutter_on      = rel[3];
        o_res.igniter_on     = rel[4];
        o_res.valve_open     = rel[5];
        o_res.valve_attached = rel[6];
        o_res.op_mode        = mode_of(o_nxt.detail);
    end

endmodule

@@ hdl/tank_fill_vent_sequencer.sv @@
// top level of the pressure-tank relay sequencer
//
//   port      dir  role     payload
//   i_req     in   sink     action, now_ms, pressure, mode_request, relay_bits
//   o_rsp     out  source   seven relay drives, op_mode
//   i_cfg_*   in   write    abort, max, min level and hysteresis band
//
// one request per cycle unless the output stalls; input register feeds result register
// state, entry time and custom relays update in the same cycle the result is registered
// synchronous active-low reset clears state, config, and both valid flags
// a stalled result holds the result register and the input register keeps one more request
module tank_fill_vent_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tfvs_req_if.sink                      i_req,
    tfvs_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tfvs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tfvs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tfvs_pkg::*;

    logic    r_in_valid;
    t_req    r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_out;
    logic    advance;
    logic    in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || advance;

    tfvs_step u_step (
        .i_cur (r_state),
        .i_req (r_in),
        .i_cfg (r_cfg),
        .o_nxt (n_state),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in.action       <= i_req.action;
            r_in.now_ms       <= i_req.now_ms;
            r_in.pressure     <= i_req.pressure;
            r_in.mode_request <= i_req.mode_request;
            r_in.relay_bits   <= i_req.relay_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.detail  <= ST_STANDBY;
            r_state.entered <= '0;
            r_state.custom  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ABORT: r_cfg.abort_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAX:   r_cfg.max_level   <= i_cfg_data[LEVEL_W-1:0];
                CFG_MIN:   r_cfg.min_level   <= i_cfg_data[LEVEL_W-1:0];
                CFG_BAND:  r_cfg.band        <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.fill_on        = r_out.fill_on;
    assign o_rsp.vent_on        = r_out.vent_on;
    assign o_rsp.abort_on       = r_out.abort_on;
    assign o_rsp.cutter_on      = r_out.cutter_on;
    assign o_rsp.igniter_on     = r_out.igniter_on;
    assign o_rsp.valve_open     = r_out.valve_open;
    assign o_rsp.valve_attached = r_out.valve_attached;
    assign o_rsp.op_mode        = r_out.op_mode;

endmodule

@@ hdl/tfvs_checker.sv @@
// port-level checks of the sequencer and their bind to the top level
module tfvs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_abort_on,
    input logic                        i_cutter_on,
    input logic                        i_valve_open,
    input logic                        i_valve_attached,
    input logic [tfvs_pkg::MODE_W-1:0] i_op_mode
);
    import tfvs_pkg::*;

    // a result stays offered until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result offered right after reset");

    a_cutter_custom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_cutter_on |-> i_op_mode == MODE_CUSTOM)
        else $error("cutter driven outside custom mode");

    a_valve_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_valve_open |-> i_valve_attached)
        else $error("valve open while detached");

    a_abort_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_abort_on |-> i_op_mode == MODE_ABORT || i_op_mode == MODE_CUSTOM)
        else $error("abort relay driven outside abort or custom mode");

endmodule

bind tank_fill_vent_sequencer tfvs_checker u_tfvs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_abort_on       (o_rsp.abort_on),
    .i_cutter_on      (o_rsp.cutter_on),
    .i_valve_open     (o_rsp.valve_open),
    .i_valve_attached (o_rsp.valve_attached),
    .i_op_mode        (o_rsp.op_mode)
);

@@ tb/tb_top.sv @@
// self-checking testbench for the tank fill and vent sequencer, relay drives predicted per request
module tb_top;
    import tfvs_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE       = 2'd3;
    localparam logic [RELAY_W-1:0]  R_CUT          = 7'b0001000;
    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  SHOWN_MAX      = 10;

    typedef enum logic [1:0] {WATCH_NONE, WATCH_DROP, WATCH_RISE} t_watch;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tfvs_req_if req_bus();
    tfvs_rsp_if rsp_bus();

    tank_fill_vent_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [LEVEL_W-1:0]  lvl_abort    = '0;
    logic [LEVEL_W-1:0]  lvl_max      = '0;
    logic [LEVEL_W-1:0]  lvl_min      = '0;
    logic [BAND_W-1:0]   lvl_band     = '0;
    logic [STATE_W-1:0]  tank_state   = ST_STANDBY;
    logic [TIME_W-1:0]   tank_entered = '0;
    logic [CUSTOM_W-1:0] tank_custom  = '0;

    t_result           expected_drive[$];
    int                fail_cnt      = 0;
    int                src_idle_pct  = 38;
    int                sink_idle_pct = 38;
    logic [TIME_W-1:0] wall_ms       = '0;

    always #5 i_clk = ~i_clk;

    function automatic void state_traits(input logic [STATE_W-1:0] s,
                                         output logic [MODE_W-1:0] mode,
                                         output logic [RELAY_W-1:0] drive,
                                         output logic [LIMIT_W-1:0] lim,
                                         output t_watch watch);
        mode  = MODE_STANDBY;
        drive = R_NONE;
        lim   = LIM_NONE;
        watch = WATCH_NONE;
        case (s)
            ST_KEEP_IN:    mode = MODE_KEEP;
            ST_KEEP_HIGH:  begin mode = MODE_KEEP; drive = R_V; end
            ST_KEEP_LOW:   begin mode = MODE_KEEP; drive = R_F; end
            ST_FILL_HI:    begin mode = MODE_FILL; drive = R_V; watch = WATCH_DROP; end
            ST_FILL_LO:    begin mode = MODE_FILL; drive = R_F; watch = WATCH_RISE; end
            ST_PURGE_HI:   begin mode = MODE_PURGE; drive = R_V; watch = WATCH_DROP; end
            ST_PURGE_LO:   begin mode = MODE_PURGE; drive = R_F | R_V; watch = WATCH_RISE; end
            ST_PFA_HI:     begin mode = MODE_PFA; drive = R_V; watch = WATCH_DROP; end
            ST_PFA_LO: begin
                mode = MODE_PFA; drive = R_F; watch = WATCH_RISE; lim = LIM_1000;
            end
            ST_PFB_HI:     begin mode = MODE_PFB; drive = R_V; watch = WATCH_DROP; end
            ST_PFB_LO: begin
                mode = MODE_PFB; drive = R_F; watch = WATCH_RISE; lim = LIM_5000;
            end
            ST_PFC_HI:     begin mode = MODE_PFC; drive = R_V; watch = WATCH_DROP; end
            ST_PFC_LO: begin
                mode = MODE_PFC; drive = R_F; watch = WATCH_RISE; lim = LIM_10000;
            end
            ST_PVA:        begin mode = MODE_PVA; drive = R_V; lim = LIM_1000; end
            ST_PVB:        begin mode = MODE_PVB; drive = R_V; lim = LIM_2000; end
            ST_PVC:        begin mode = MODE_PVC; drive = R_V; lim = LIM_5000; end
            ST_PPA_HI:     begin mode = MODE_PPA; drive = R_V; watch = WATCH_DROP; end
            ST_PPA_LO: begin
                mode = MODE_PPA; drive = R_F | R_V; watch = WATCH_RISE; lim = LIM_1000;
            end
            ST_PPB_HI:     begin mode = MODE_PPB; drive = R_V; watch = WATCH_DROP; end
            ST_PPB_LO: begin
                mode = MODE_PPB; drive = R_F | R_V; watch = WATCH_RISE; lim = LIM_2000;
            end
            ST_PPC_HI:     begin mode = MODE_PPC; drive = R_V; watch = WATCH_DROP; end
            ST_PPC_LO: begin
                mode = MODE_PPC; drive = R_F | R_V; watch = WATCH_RISE; lim = LIM_5000;
            end
            ST_FIRE_IGN:   begin mode = MODE_FIRE; drive = R_I | R_T; lim = LIM_10000; end
            ST_FIRE_BUF:   begin mode = MODE_FIRE; drive = R_T; lim = LIM_500; end
            ST_FIRE_VALVE: begin mode = MODE_FIRE; drive = R_S | R_T; lim = LIM_30000; end
            ST_MAN_IGN:    begin mode = MODE_MAN_IGN; drive = R_I | R_T; end
            ST_MAN_VALVE:  begin mode = MODE_MAN_VALVE; drive = R_S | R_T; end
            ST_ABORT:      begin mode = MODE_ABORT; drive = R_A; end
            ST_CUSTOM:     mode = MODE_CUSTOM;
            default:       ;
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] mode_entry(input logic [MODE_W-1:0] m);
        case (m)
            MODE_KEEP:      return ST_KEEP_IN;
            MODE_FILL:      return ST_FILL_LO;
            MODE_PURGE:     return ST_PURGE_LO;
            MODE_PFA:       return ST_PFA_LO;
            MODE_PFB:       return ST_PFB_LO;
            MODE_PFC:       return ST_PFC_LO;
            MODE_PVA:       return ST_PVA;
            MODE_PVB:       return ST_PVB;
            MODE_PVC:       return ST_PVC;
            MODE_PPA:       return ST_PPA_LO;
            MODE_PPB:       return ST_PPB_LO;
            MODE_PPC:       return ST_PPC_LO;
            MODE_FIRE:      return ST_FIRE_IGN;
            MODE_MAN_IGN:   return ST_MAN_IGN;
            MODE_MAN_VALVE: return ST_MAN_VALVE;
            MODE_ABORT:     return ST_ABORT;
            default:        return ST_STANDBY;
        endcase
    endfunction

    // advances the tank state by one request and returns the relay drives after it
    function automatic t_result relay_outcome(input t_req r);
        longint              p;
        longint              band;
        logic                ab_hi, ab_lo, mx_hi, mx_lo, mn_hi, mn_lo;
        logic                timed_out, stamp;
        logic [TIME_W-1:0]   elapsed;
        logic [STATE_W-1:0]  next;
        logic [MODE_W-1:0]   mode;
        logic [RELAY_W-1:0]  drive;
        logic [LIMIT_W-1:0]  lim;
        t_watch              watch;
        t_result             res;
        p     = longint'($signed(r.pressure));
        band  = longint'(lvl_band);
        ab_hi = p > longint'(lvl_abort) + band;
        ab_lo = p < longint'(lvl_abort) - band;
        mx_hi = p > longint'(lvl_max) + band;
        mx_lo = p < longint'(lvl_max) - band;
        mn_hi = p > longint'(lvl_min) + band;
        mn_lo = p < longint'(lvl_min) - band;
        elapsed = r.now_ms - tank_entered;
        state_traits(tank_state, mode, drive, lim, watch);
        timed_out = (lim != LIM_NONE) && (elapsed > lim);
        next  = tank_state;
        stamp = 1'b0;
        case (r.action)
            ACT_TICK: begin
                if (tank_state == ST_KEEP_IN) begin
                    if (mx_hi) next = ST_KEEP_HIGH;
                    else if (mn_lo) next = ST_KEEP_LOW;
                end else if (tank_state == ST_KEEP_HIGH) begin
                    if (mx_lo) next = ST_KEEP_IN;
                end else if (tank_state == ST_KEEP_LOW) begin
                    if (mn_hi) next = ST_KEEP_IN;
                end else if (watch == WATCH_DROP) begin
                    if (ab_lo) next = tank_state + 1'b1;
                end else if (watch == WATCH_RISE) begin
                    if (ab_hi) next = tank_state - 1'b1;
                    else if (timed_out) next = ST_STANDBY;
                end else if (tank_state == ST_FIRE_IGN) begin
                    if (timed_out) next = ST_FIRE_BUF;
                end else if (tank_state == ST_FIRE_BUF) begin
                    if (timed_out) next = ST_FIRE_VALVE;
                end else if (timed_out) begin
                    next = ST_STANDBY;
                end
                stamp = (next != tank_state);
            end
            ACT_MODE: begin
                if (r.mode_request < MODE_CUSTOM) begin
                    next  = mode_entry(r.mode_request);
                    stamp = 1'b1;
                end
            end
            ACT_CUSTOM: begin
                tank_custom = r.relay_bits[CUSTOM_W-1:0];
                next        = ST_CUSTOM;
                stamp       = 1'b1;
            end
            default: ;
        endcase
        if (stamp) begin
            tank_state   = next;
            tank_entered = r.now_ms;
        end
        state_traits(tank_state, mode, drive, lim, watch);
        if (tank_state == ST_CUSTOM) drive = {tank_custom[VALVE_BIT], tank_custom};
        res.fill_on        = |(drive & R_F);
        res.vent_on        = |(drive & R_V);
        res.abort_on       = |(drive & R_A);
        res.cutter_on      = |(drive & R_CUT);
        res.igniter_on     = |(drive & R_I);
        res.valve_open     = |(drive & R_S);
        res.valve_attached = |(drive & R_T);
        res.op_mode        = mode;
        return res;
    endfunction

    function automatic t_req mk_req(input logic [ACTION_W-1:0] a, input logic [TIME_W-1:0] t,
                                    input logic [PRESSURE_W-1:0] p,
                                    input logic [MODE_W-1:0] m,
                                    input logic [RELAY_IN_W-1:0] b);
        t_req r;
        r.action       = a;
        r.now_ms       = t;
        r.pressure     = p;
        r.mode_request = m;
        r.relay_bits   = b;
        return r;
    endfunction

    function automatic t_req rand_req();
        t_req        r;
        logic [31:0] rnd;
        rnd            = $urandom;
        r.action       = rnd[ACTION_W-1:0];
        rnd            = $urandom;
        r.now_ms       = rnd;
        rnd            = $urandom;
        r.pressure     = rnd[PRESSURE_W-1:0];
        rnd            = $urandom;
        r.mode_request = rnd[MODE_W-1:0];
        rnd            = $urandom;
        r.relay_bits   = rnd[RELAY_IN_W-1:0];
        return r;
    endfunction

    // tick aimed at the running timer limit and at the threshold band edges
    function automatic t_req rand_tick();
        t_req               r;
        logic [MODE_W-1:0]  m;
        logic [RELAY_W-1:0] d;
        logic [LIMIT_W-1:0] lim;
        t_watch             w;
        longint             lvl;
        longint             p;
        int                 pick;
        r      = rand_req();
        r.action = ACT_TICK;
        pick   = $urandom_range(99);
        if (pick < 40) begin
            state_traits(tank_state, m, d, lim, w);
            if (lim == LIM_NONE || $urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0:       lim = LIM_500;
                    1:       lim = LIM_1000;
                    2:       lim = LIM_2000;
                    3:       lim = LIM_5000;
                    4:       lim = LIM_10000;
                    default: lim = LIM_30000;
                endcase
            end
            wall_ms = tank_entered + lim - 32'd1 + $urandom_range(2);
        end else if (pick < 75) begin
            wall_ms = wall_ms + $urandom_range(400);
        end else if (pick < 90) begin
            wall_ms = wall_ms + $urandom_range(40000);
        end else begin
            wall_ms = $urandom;
        end
        r.now_ms = wall_ms;
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(2))
                0:       lvl = longint'(lvl_abort);
                1:       lvl = longint'(lvl_max);
                default: lvl = longint'(lvl_min);
            endcase
            p = ($urandom_range(1) == 1) ? lvl + longint'(lvl_band) : lvl - longint'(lvl_band);
            p = p + longint'($urandom_range(4)) - 2;
            if (p >= -(longint'(1) << (PRESSURE_W - 1)) && p < (longint'(1) << (PRESSURE_W - 1)))
                r.pressure = p[PRESSURE_W-1:0];
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.action       <= r.action;
        req_bus.now_ms       <= r.now_ms;
        req_bus.pressure     <= r.pressure;
        req_bus.mode_request <= r.mode_request;
        req_bus.relay_bits   <= r.relay_bits;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do @(negedge i_clk); while (expected_drive.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ABORT: lvl_abort = data;
            CFG_MAX:   lvl_max   = data;
            CFG_MIN:   lvl_min   = data;
            CFG_BAND:  lvl_band  = data[BAND_W-1:0];
            default:   ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_levels(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] mx,
                              input logic [CFG_DATA_W-1:0] mn, input logic [CFG_DATA_W-1:0] b);
        drain_results();
        write_reg(CFG_ABORT, a);
        write_reg(CFG_MAX, mx);
        write_reg(CFG_MIN, mn);
        write_reg(CFG_BAND, b);
    endtask

    // a mode command (valid or out of range), custom load, idle action or tick, followed by a run of ticks
    task automatic run_sessions(input int n);
        int   sent;
        int   pick;
        t_req r;
        sent = 0;
        while (sent < n) begin
            r        = rand_req();
            r.now_ms = wall_ms;
            pick     = $urandom_range(99);
            if (pick < 70) begin
                r.action       = ACT_MODE;
                r.mode_request = MODE_W'($urandom_range(MODE_ABORT));
                sent++;
            end else if (pick < 80) begin
                r.action = ACT_CUSTOM;
                sent++;
            end else if (pick < 88) begin
                r.action       = ACT_MODE;
                r.mode_request = MODE_W'($urandom_range(31, MODE_CUSTOM));
            end else if (pick < 93) begin
                r.action = ACT_NONE;
            end else begin
                r.action = ACT_TICK;
                sent++;
            end
            send_req(r);
            repeat ($urandom_range(12, 2)) begin
                send_req(rand_tick());
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [TIME_W-1:0] t0;
        set_levels(23'd2000, 23'd1000, 23'd500, 23'd100);
        send_req(mk_req(ACT_TICK, '0, 24'h7FFFFF, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, '1, 24'h800000, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_NONE, '1, '1, '1, '1));
        send_req(mk_req(ACT_MODE, 32'd7, '0, MODE_CUSTOM, 8'h00));
        send_req(mk_req(ACT_MODE, 32'd8, '0, 5'h1F, 8'h00));
        send_req(mk_req(ACT_CUSTOM, 32'd9, '0, MODE_STANDBY, 8'hFF));
        send_req(mk_req(ACT_CUSTOM, 32'd10, '0, MODE_STANDBY, 8'hC0));
        // fire sequence across the timestamp wrap, each limit passed by one, the first two also hit
        t0 = 32'hFFFF_F000;
        send_req(mk_req(ACT_MODE, t0, '0, MODE_FIRE, 8'h00));
        send_req(mk_req(ACT_TICK, t0 + 32'd10000, '0, MODE_STANDBY, 8'h00));
        t0 = t0 + 32'd10001;
        send_req(mk_req(ACT_TICK, t0, '0, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, t0 + 32'd500, '0, MODE_STANDBY, 8'h00));
        t0 = t0 + 32'd501;
        send_req(mk_req(ACT_TICK, t0, '0, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, t0 + 32'd30001, '0, MODE_STANDBY, 8'h00));
        // keep band edges
        send_req(mk_req(ACT_MODE, 32'd100, '0, MODE_KEEP, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd1100, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd1101, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd900, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd899, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd399, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd200, 24'd601, MODE_STANDBY, 8'h00));
        // abort band in fill, then the PVA timer limit passed
        send_req(mk_req(ACT_MODE, 32'd300, '0, MODE_FILL, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd400, 24'd2101, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd400, 24'd1899, MODE_STANDBY, 8'h00));
        send_req(mk_req(ACT_MODE, 32'd5000, '0, MODE_PVA, 8'h00));
        send_req(mk_req(ACT_TICK, 32'd6001, '0, MODE_STANDBY, 8'h00));
    endtask

    task automatic test_near_levels();
        logic [CFG_DATA_W-1:0] mx;
        mx = CFG_DATA_W'($urandom_range(20000));
        set_levels(CFG_DATA_W'($urandom_range(20000)), mx, CFG_DATA_W'($urandom_range(mx)),
                   CFG_DATA_W'($urandom_range(300)));
        wall_ms = $urandom;
        run_sessions(200);
        drain_results();
        run_sessions(200);
    endtask

    task automatic test_back_to_back();
        logic [CFG_DATA_W-1:0] mx;
        mx = CFG_DATA_W'($urandom_range(50000));
        set_levels(CFG_DATA_W'($urandom_range(50000)), mx, CFG_DATA_W'($urandom_range(mx)),
                   CFG_DATA_W'($urandom_range(1000)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_sessions(250);
        src_idle_pct  = 38;
        sink_idle_pct = 38;
    endtask

    task automatic test_extreme_levels();
        set_levels('1, '1, '1, '1);
        run_sessions(200);
    endtask

    task automatic test_zero_levels();
        set_levels('0, '0, '0, '0);
        wall_ms = '1 - 32'd20000;
        run_sessions(200);
    endtask

    task automatic test_wide_random();
        set_levels(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom));
        run_sessions(250);
    endtask

    always @(posedge i_clk) begin : track_requests
        t_req taken;
        if (req_bus.valid && req_bus.ready) begin
            taken.action       = req_bus.action;
            taken.now_ms       = req_bus.now_ms;
            taken.pressure     = req_bus.pressure;
            taken.mode_request = req_bus.mode_request;
            taken.relay_bits   = req_bus.relay_bits;
            expected_drive.push_back(relay_outcome(taken));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        string   bad;
        if (rsp_bus.valid && rsp_bus.ready) begin
            seen.fill_on        = rsp_bus.fill_on;
            seen.vent_on        = rsp_bus.vent_on;
            seen.abort_on       = rsp_bus.abort_on;
            seen.cutter_on      = rsp_bus.cutter_on;
            seen.igniter_on     = rsp_bus.igniter_on;
            seen.valve_open     = rsp_bus.valve_open;
            seen.valve_attached = rsp_bus.valve_attached;
            seen.op_mode        = rsp_bus.op_mode;
            if (expected_drive.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= SHOWN_MAX)
                    $display("unexpected result: relays %b mode %0d",
                             seen[$bits(t_result)-1:MODE_W], seen.op_mode);
            end else begin
                want = expected_drive.pop_front();
                bad  = "";
                if (seen.fill_on !== want.fill_on) bad = {bad, " fill_on"};
                if (seen.vent_on !== want.vent_on) bad = {bad, " vent_on"};
                if (seen.abort_on !== want.abort_on) bad = {bad, " abort_on"};
                if (seen.cutter_on !== want.cutter_on) bad = {bad, " cutter_on"};
                if (seen.igniter_on !== want.igniter_on) bad = {bad, " igniter_on"};
                if (seen.valve_open !== want.valve_open) bad = {bad, " valve_open"};
                if (seen.valve_attached !== want.valve_attached) bad = {bad, " valve_attached"};
                if (seen.op_mode !== want.op_mode) bad = {bad, " op_mode"};
                if (bad != "") begin
                    fail_cnt++;
                    if (fail_cnt <= SHOWN_MAX)
                        $display("mismatch in%s: expected relays %b mode %0d, got relays %b mode %0d",
                                 bad, want[$bits(t_result)-1:MODE_W], want.op_mode,
                                 seen[$bits(t_result)-1:MODE_W], seen.op_mode);
                end
            end
        end
    end

    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[tank_fill_vent_sequencer] ERROR");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_ABORT;
        cfg_data             = '0;
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_TICK;
        req_bus.now_ms       = '0;
        req_bus.pressure     = '0;
        req_bus.mode_request = MODE_STANDBY;
        req_bus.relay_bits   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_near_levels();
        test_back_to_back();
        test_extreme_levels();
        test_zero_levels();
        test_wide_random();
        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_cnt == 0 && expected_drive.size() == 0)
            $display("[tank_fill_vent_sequencer] OK");
        else
            $display("[tank_fill_vent_sequencer] ERROR");
        $finish;
    end

endmodule
